// ===== hdl/rotated_sorted_array_search_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the rotated sorted array search block
// Clocked, reset-qualified property checks; compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef ROTATED_SORTED_ARRAY_SEARCH_ASSERT_SVH
`define ROTATED_SORTED_ARRAY_SEARCH_ASSERT_SVH

`ifndef ASSERT_OFF

// Condition holds at every clock edge out of reset
`define RSAS_ASSERT(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("rsas assertion failed");

// Same-cycle implication
`define RSAS_ASSERT_IMPL(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("rsas implication failed");

// Next-cycle implication
`define RSAS_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("rsas next-cycle check failed");

`else

`define RSAS_ASSERT(lbl, clk, rstn, cond)
`define RSAS_ASSERT_IMPL(lbl, clk, rstn, pre, post)
`define RSAS_ASSERT_NEXT(lbl, clk, rstn, pre, post)

`endif

`endif

// ===== hdl/rsas_pkg.sv =====
// ---------------------------------------------------------------------------
// rsas_pkg
// Shared types and constants of the rotated sorted array search block.
// ---------------------------------------------------------------------------
`default_nettype none

package rsas_pkg;

    // Field widths
    localparam int DATA_W        = 32;
    localparam int FUNC_W        = 2;
    localparam int POS_W         = 10;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 16;

    // Defaults and sizes
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int QUEUE_DEPTH      = 4;

    // Function codes on the input channel
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    // Decoded operation carried through the queue
    typedef enum logic [1:0] {
        OP_APPEND,
        OP_SEARCH,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    // Queue status toward the back end
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_LO,
        S_RD_HI,
        S_CMP_LH,
        S_RD_NXT,
        S_RD_PRV,
        S_CMP_MID,
        S_PIV_RD,
        S_PIV_CMP,
        S_BS_CHK,
        S_BS_CMP,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/rsas_ram.sv =====
// ---------------------------------------------------------------------------
// rsas_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rsas_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rsas_fifo.sv =====
// ---------------------------------------------------------------------------
// rsas_fifo
// Short command queue between the decode front end and the search engine.
// ---------------------------------------------------------------------------
`default_nettype none

module rsas_fifo
    import rsas_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire cmd_t      push_cmd,
    input  wire logic      pop,
    output cmd_t           head_cmd,
    output q_status_t      status
);

`include "rotated_sorted_array_search_assert.svh"

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign head_cmd     = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `RSAS_ASSERT(a_no_push_full, aclk, aresetn, !(push && status.full))
    `RSAS_ASSERT(a_no_pop_empty, aclk, aresetn, !(pop && status.empty))
    `RSAS_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= CNT_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

// ===== hdl/rsas_front.sv =====
// ---------------------------------------------------------------------------
// rsas_front
// Input side: takes transfers, decodes the function code, drops unused codes.
// ---------------------------------------------------------------------------
`default_nettype none

module rsas_front
    import rsas_pkg::*;
(
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [FUNC_W-1:0]    s_tuser,
    input  wire q_status_t            q_status,
    output logic                      push,
    output cmd_t                      push_cmd
);

    logic known_func;

    // Accept whenever the queue has room
    assign s_tready = !q_status.full;

    // Decode function code
    always_comb begin
        known_func     = 1'b1;
        push_cmd.op    = OP_APPEND;
        push_cmd.value = $signed(s_tdata[DATA_W-1:0]);
        unique case (s_tuser)
            FUNC_APPEND: push_cmd.op = OP_APPEND;
            FUNC_SEARCH: push_cmd.op = OP_SEARCH;
            FUNC_CLEAR:  push_cmd.op = OP_CLEAR;
            default:     known_func  = 1'b0;
        endcase
    end

    // Unused code is consumed without effect
    assign push = s_tvalid && s_tready && known_func;

endmodule

`default_nettype wire

// ===== hdl/rsas_back.sv =====
// ---------------------------------------------------------------------------
// rsas_back
// Search engine: owns the element store, executes append, clear and search.
// ---------------------------------------------------------------------------
`default_nettype none

module rsas_back
    import rsas_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cmd_t                 q_cmd,
    input  wire q_status_t            q_status,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata
);

`include "rotated_sorted_array_search_assert.svh"

    localparam int AW  = $clog2(MAX_ELEMENTS);
    localparam int CW  = $clog2(MAX_ELEMENTS + 1);
    localparam int IW  = AW + 2;
    localparam int PAD = M_TDATA_W - POS_W - 2;

    // Control and index registers
    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic                     dropped_reg, dropped_next;
    logic signed [IW-1:0]     lo_reg, lo_next;
    logic signed [IW-1:0]     hi_reg, hi_next;
    logic signed [IW-1:0]     mid_reg, mid_next;
    logic signed [IW-1:0]     pivot_reg, pivot_next;
    logic                     range2_reg, range2_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic signed [DATA_W-1:0] lo_val_reg, lo_val_next;
    logic signed [DATA_W-1:0] mid_val_reg, mid_val_next;
    logic signed [DATA_W-1:0] nxt_val_reg, nxt_val_next;
    logic                     found_reg, found_next;
    logic [AW-1:0]            idx_reg, idx_next;
    logic                     m_valid_reg;
    logic [M_TDATA_W-1:0]     m_data_reg;

    // Memory port signals
    logic                     wr_en;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic [DATA_W-1:0]        rd_data;
    logic signed [DATA_W-1:0] rd_val;

    // Index arithmetic
    logic signed [IW-1:0]     n_s;
    logic signed [IW-1:0]     mid_calc;
    logic signed [IW-1:0]     mid_inc;
    logic signed [IW-1:0]     nxt_calc;
    logic signed [IW-1:0]     prv_calc;
    logic signed [IW-1:0]     lo_step;
    logic signed [IW-1:0]     hi_step;
    logic                     load_out;

    assign rd_val   = $signed(rd_data);
    assign n_s      = signed'(IW'(count_reg));
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >>> 1);
    assign mid_inc  = mid_reg + IW'(1);
    // Wrap-around neighbors of the middle element
    assign nxt_calc = (mid_inc == n_s) ? '0 : mid_inc;
    assign prv_calc = (mid_reg == '0) ? (n_s - IW'(1)) : (mid_reg - IW'(1));

    rsas_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (q_cmd.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer: next state, datapath updates, memory accesses
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        pivot_next   = pivot_reg;
        range2_next  = range2_reg;
        key_next     = key_reg;
        lo_val_next  = lo_val_reg;
        mid_val_next = mid_val_reg;
        nxt_val_next = nxt_val_reg;
        found_next   = found_reg;
        idx_next     = idx_reg;
        lo_step      = lo_reg;
        hi_step      = hi_reg;
        pop          = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        load_out     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (!q_status.empty) begin
                    pop = 1'b1;
                    case (q_cmd.op)
                        OP_APPEND: begin
                            if (count_reg < CW'(MAX_ELEMENTS)) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end else begin
                                dropped_next = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            count_next   = '0;
                            dropped_next = 1'b0;
                        end
                        OP_SEARCH: begin
                            key_next = q_cmd.value;
                            if (count_reg == '0) begin
                                found_next = 1'b0;
                                idx_next   = '0;
                                state_next = S_DONE;
                            end else if (count_reg == CW'(1)) begin
                                pivot_next = '0;
                                state_next = S_PIV_RD;
                            end else begin
                                lo_next    = '0;
                                hi_next    = n_s - IW'(1);
                                state_next = S_RD_LO;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // Pivot search: fetch both ends of the window
            S_RD_LO: begin
                rd_en      = 1'b1;
                rd_addr    = lo_reg[AW-1:0];
                state_next = S_RD_HI;
            end
            S_RD_HI: begin
                lo_val_next = rd_val;
                rd_en       = 1'b1;
                rd_addr     = hi_reg[AW-1:0];
                state_next  = S_CMP_LH;
            end
            S_CMP_LH: begin
                if (lo_val_reg <= rd_val) begin
                    pivot_next = lo_reg;
                    state_next = S_PIV_RD;
                end else begin
                    mid_next   = mid_calc;
                    rd_en      = 1'b1;
                    rd_addr    = mid_calc[AW-1:0];
                    state_next = S_RD_NXT;
                end
            end
            S_RD_NXT: begin
                mid_val_next = rd_val;
                rd_en        = 1'b1;
                rd_addr      = nxt_calc[AW-1:0];
                state_next   = S_RD_PRV;
            end
            S_RD_PRV: begin
                nxt_val_next = rd_val;
                rd_en        = 1'b1;
                rd_addr      = prv_calc[AW-1:0];
                state_next   = S_CMP_MID;
            end
            S_CMP_MID: begin
                if (mid_val_reg <= nxt_val_reg && mid_val_reg <= rd_val) begin
                    pivot_next = mid_reg;
                    state_next = S_PIV_RD;
                end else begin
                    if (lo_val_reg <= mid_val_reg) begin
                        lo_step = mid_inc;
                    end else begin
                        hi_step = mid_reg - IW'(1);
                    end
                    lo_next = lo_step;
                    hi_next = hi_step;
                    if (lo_step <= hi_step) begin
                        state_next = S_RD_LO;
                    end else begin
                        pivot_next = '0;
                        state_next = S_PIV_RD;
                    end
                end
            end
            // Compare the pivot element itself
            S_PIV_RD: begin
                rd_en      = 1'b1;
                rd_addr    = pivot_reg[AW-1:0];
                state_next = S_PIV_CMP;
            end
            S_PIV_CMP: begin
                if (rd_val == key_reg) begin
                    found_next = 1'b1;
                    idx_next   = pivot_reg[AW-1:0];
                    state_next = S_DONE;
                end else begin
                    lo_next     = '0;
                    hi_next     = pivot_reg - IW'(1);
                    range2_next = 1'b0;
                    state_next  = S_BS_CHK;
                end
            end
            // Binary search over the part before, then from the pivot on
            S_BS_CHK: begin
                if (lo_reg <= hi_reg) begin
                    mid_next   = mid_calc;
                    rd_en      = 1'b1;
                    rd_addr    = mid_calc[AW-1:0];
                    state_next = S_BS_CMP;
                end else if (!range2_reg) begin
                    lo_next     = pivot_reg;
                    hi_next     = n_s - IW'(1);
                    range2_next = 1'b1;
                end else begin
                    found_next = 1'b0;
                    idx_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_BS_CMP: begin
                if (rd_val == key_reg) begin
                    found_next = 1'b1;
                    idx_next   = mid_reg[AW-1:0];
                    state_next = S_DONE;
                end else begin
                    if (key_reg < rd_val) begin
                        hi_next = mid_reg - IW'(1);
                    end else begin
                        lo_next = mid_inc;
                    end
                    state_next = S_BS_CHK;
                end
            end
            // Hand the result to the output register once it is free
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        pivot_reg   <= pivot_next;
        range2_reg  <= range2_next;
        key_reg     <= key_next;
        lo_val_reg  <= lo_val_next;
        mid_val_reg <= mid_val_next;
        nxt_val_reg <= nxt_val_next;
        found_reg   <= found_next;
        idx_reg     <= idx_next;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= {PAD'(0), dropped_reg, POS_W'(idx_reg), found_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `RSAS_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CW'(MAX_ELEMENTS))
    `RSAS_ASSERT_IMPL(a_wr_in_range, aclk, aresetn, wr_en, count_reg < CW'(MAX_ELEMENTS))
    `RSAS_ASSERT_NEXT(a_clear, aclk, aresetn, pop && q_cmd.op == OP_CLEAR, count_reg == '0 && !dropped_reg)
    `RSAS_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, load_out, !m_valid_reg || m_tready)
    `RSAS_ASSERT_IMPL(a_probe_range, aclk, aresetn, state_reg == S_BS_CMP, mid_reg >= 0 && mid_reg < n_s)

endmodule

`default_nettype wire

// ===== hdl/rotated_sorted_array_search.sv =====
// An append or clear takes effect when the engine, while idle, pops it from the command queue.
// A search reads both window ends per pivot step, then the middle and its two neighbours unless
// the ends are in order; it then compares the pivot and probes the ranges before and from it.
// Throughput: appends and clears one per cycle while the engine is idle and the queue has room;
// one search at a time, set by the single read port of the element store (empty array: no reads).
// Reset: count, dropped flag, queue and output valid clear; store contents are not cleared.
// ---------------------------------------------------------------------------
// rotated_sorted_array_search
// Stores appended elements and searches them as a rotated ascending array.
// ---------------------------------------------------------------------------
`default_nettype none

module rotated_sorted_array_search
    import rsas_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
    input  wire logic [FUNC_W-1:0]    s_tuser,   // [1:0] func
    // Result channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // [0] found, [10:1] position, [11] overflow
);

    cmd_t      push_cmd;
    cmd_t      head_cmd;
    q_status_t q_status;
    logic      push;
    logic      pop;

    // Decode front end
    rsas_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Command queue
    rsas_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    // Search engine with element store
    rsas_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_cmd    (head_cmd),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
